### sv/two_axis_slew_and_end_limiter_core_assert.svh
// Assertion macros shared by the limiter core.
`ifndef TWO_AXIS_SLEW_AND_END_LIMITER_CORE_ASSERT_SVH
`define TWO_AXIS_SLEW_AND_END_LIMITER_CORE_ASSERT_SVH

// same-cycle implication
`define TASEL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tasel assertion failed");

// next-cycle implication
`define TASEL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tasel assertion failed");

`endif

### sv/tasel_pkg.sv
`timescale 1ns / 1ps

package tasel_pkg;

    localparam int DRV_W      = 16;
    localparam int POS_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 4;
    localparam int SPD_W      = 15;
    localparam int ACC_W      = 16;
    localparam int TS_FRAC    = 16;
    localparam int FRAC_W     = 14;
    localparam int QUO_W      = FRAC_W + 1;
    localparam int DIST_W     = 17;
    localparam int ZONE_W     = 17;
    localparam int LIM_W      = 18;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CNT_W      = $clog2(QUO_W + 1);

    localparam logic signed [DRV_W-1:0] DRV_ONE = DRV_W'(1 << FRAC_W);

    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_LOWER = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_TSTEP = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOWF = CFG_ADDR_W'(3);

    localparam logic signed [POS_W-1:0] UPPER_RST = 16'sh7FFF;
    localparam logic signed [POS_W-1:0] LOWER_RST = 16'sh8000;
    localparam logic [CFG_W-1:0]        TSTEP_RST = 16'd655;
    localparam logic [CFG_W-1:0]        SLOWF_RST = 16'd9830;

    typedef enum logic [1:0] {
        MUL_PITCH,
        MUL_YAW,
        MUL_ZONE
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_LIMIT,
        ST_DIVH_GO,
        ST_DIVH_RUN,
        ST_APPLY_HI,
        ST_DIVL_GO,
        ST_DIVL_RUN,
        ST_APPLY_LO,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     limit;
        logic     div_start;
        logic     div_lo;
        logic     apply_hi;
        logic     apply_lo;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_last;
    } stat_t;

    // when the bounds cross, inputs below the low bound give the low bound and all others the high bound
    function automatic logic signed [DRV_W-1:0] clamp_drv(
        input logic signed [DRV_W-1:0] x,
        input logic signed [DRV_W-1:0] lo,
        input logic signed [DRV_W-1:0] hi
    );
        logic signed [DRV_W-1:0] r;
        if (x < lo) begin
            r = lo;
        end else if (x > hi) begin
            r = hi;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

### sv/tasel_div.sv
`timescale 1ns / 1ps

module tasel_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tasel_pkg::DIST_W-1:0] dividend,
    input  logic [tasel_pkg::DIST_W-1:0] divisor,
    output logic [tasel_pkg::QUO_W-1:0]  quotient,
    output tasel_pkg::stat_t             stat
);
    import tasel_pkg::*;

    // Computes (dividend << FRAC_W) / divisor, one quotient bit per cycle.
    // Valid when dividend <= divisor, so the quotient fits QUO_W bits.
    logic [DIST_W-1:0] rem_reg;
    logic [DIST_W-1:0] dvs_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              lsb_reg;

    logic              in_bit;
    logic [DIST_W:0]   trial;
    logic [DIST_W:0]   diff;
    logic              ge;

    always_comb begin
        in_bit = (cnt_reg == CNT_W'(QUO_W)) ? lsb_reg : 1'b0;
        trial  = {rem_reg, in_bit};
        diff   = trial - {1'b0, dvs_reg};
        ge     = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(QUO_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, dividend[DIST_W-1:1]};
            lsb_reg <= dividend[0];
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign quotient      = quo_reg;
    assign stat.div_busy = (cnt_reg != '0);
    assign stat.div_last = (cnt_reg == CNT_W'(1));

endmodule

### sv/tasel_dp.sv
`timescale 1ns / 1ps

module tasel_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tasel_pkg::cmd_t                     cmd,
    output tasel_pkg::stat_t                    stat,
    input  logic                                cfg_wr_en,
    input  logic [tasel_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tasel_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic signed [tasel_pkg::DRV_W-1:0]  in_pitch_demand,
    input  logic signed [tasel_pkg::DRV_W-1:0]  in_yaw_demand,
    input  logic [tasel_pkg::SPD_W-1:0]         in_pitch_speed_limit,
    input  logic [tasel_pkg::SPD_W-1:0]         in_yaw_speed_limit,
    input  logic [tasel_pkg::ACC_W-1:0]         in_pitch_accel_limit,
    input  logic [tasel_pkg::ACC_W-1:0]         in_yaw_accel_limit,
    input  logic signed [tasel_pkg::POS_W-1:0]  in_measured_pitch_position,
    output logic signed [tasel_pkg::DRV_W-1:0]  pitch_drive,
    output logic signed [tasel_pkg::DRV_W-1:0]  yaw_drive
);
    import tasel_pkg::*;

    localparam int SLW_W = DRV_W + 2;

    function automatic logic signed [DRV_W-1:0] slew(
        input logic signed [DRV_W-1:0] cur,
        input logic signed [DRV_W-1:0] dem,
        input logic [ACC_W-1:0]        step
    );
        logic signed [SLW_W-1:0] c;
        logic signed [SLW_W-1:0] d;
        logic signed [SLW_W-1:0] up;
        logic signed [SLW_W-1:0] dn;
        logic signed [SLW_W-1:0] r;
        c  = SLW_W'(cur);
        d  = SLW_W'(dem);
        up = c + signed'(SLW_W'(step));
        dn = c - signed'(SLW_W'(step));
        if (c < d) begin
            r = (up > d) ? d : up;
        end else if (c > d) begin
            r = (dn < d) ? d : dn;
        end else begin
            r = c;
        end
        return r[DRV_W-1:0];
    endfunction

    // configuration
    logic signed [POS_W-1:0] upper_reg;
    logic signed [POS_W-1:0] lower_reg;
    logic [CFG_W-1:0]        tstep_reg;
    logic [CFG_W-1:0]        slowf_reg;

    // captured word
    logic signed [DRV_W-1:0] pdem_reg;
    logic signed [DRV_W-1:0] ydem_reg;
    logic [SPD_W-1:0]        pspd_reg;
    logic [SPD_W-1:0]        yspd_reg;
    logic [ACC_W-1:0]        pacc_reg;
    logic [ACC_W-1:0]        yacc_reg;
    logic signed [POS_W-1:0] mpos_reg;

    // working values
    logic [ACC_W-1:0]         pstep_reg;
    logic [ACC_W-1:0]         ystep_reg;
    logic signed [ZONE_W-1:0] travel_reg;
    logic signed [ZONE_W-1:0] zone_reg;
    logic signed [LIM_W-1:0]  hi_lim_reg;
    logic signed [LIM_W-1:0]  lo_lim_reg;
    logic signed [DRV_W-1:0]  p_reg;
    logic signed [DRV_W-1:0]  y_reg;
    logic                     up_past_reg;
    logic                     up_zone_reg;
    logic                     lo_past_reg;
    logic                     lo_zone_reg;

    // stored drives, also the result word
    logic signed [DRV_W-1:0]  pdrive_reg;
    logic signed [DRV_W-1:0]  ydrive_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [DRV_W-1:0]  psp;
    logic signed [DRV_W-1:0]  ysp;
    logic signed [LIM_W-1:0]  m_ext;
    logic signed [LIM_W:0]    dist_hi;
    logic signed [ZONE_W-1:0] dist_lo;
    logic [DIST_W-1:0]        div_num;
    logic [QUO_W-1:0]         quo;
    logic signed [DRV_W-1:0]  ratio;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= UPPER_RST;
            lower_reg <= LOWER_RST;
            tstep_reg <= TSTEP_RST;
            slowf_reg <= SLOWF_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_UPPER: upper_reg <= signed'(cfg_wdata[POS_W-1:0]);
                CFG_LOWER: lower_reg <= signed'(cfg_wdata[POS_W-1:0]);
                CFG_TSTEP: tstep_reg <= cfg_wdata;
                CFG_SLOWF: slowf_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pdem_reg <= clamp_drv(in_pitch_demand, -DRV_ONE, DRV_ONE);
            ydem_reg <= clamp_drv(in_yaw_demand, -DRV_ONE, DRV_ONE);
            pspd_reg <= in_pitch_speed_limit;
            yspd_reg <= in_yaw_speed_limit;
            pacc_reg <= in_pitch_accel_limit;
            yacc_reg <= in_yaw_accel_limit;
            mpos_reg <= in_measured_pitch_position;
        end
    end

    // shared multiplier: two slew steps, then the slowdown zone
    always_comb begin
        case (cmd.mul_sel)
            MUL_PITCH: begin
                mul_a = signed'(MUL_W'(pacc_reg));
                mul_b = signed'(MUL_W'(tstep_reg));
            end
            MUL_YAW: begin
                mul_a = signed'(MUL_W'(yacc_reg));
                mul_b = signed'(MUL_W'(tstep_reg));
            end
            MUL_ZONE: begin
                mul_a = travel_reg;
                mul_b = signed'(MUL_W'(slowf_reg));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            case (cmd.mul_sel)
                MUL_PITCH: begin
                    pstep_reg  <= prod[TS_FRAC+ACC_W-1:TS_FRAC];
                    travel_reg <= ZONE_W'(upper_reg) - ZONE_W'(lower_reg);
                end
                MUL_YAW:  ystep_reg <= prod[TS_FRAC+ACC_W-1:TS_FRAC];
                MUL_ZONE: zone_reg  <= prod[TS_FRAC+ZONE_W-1:TS_FRAC];
                default: ;
            endcase
        end
    end

    always_comb begin
        psp     = signed'(DRV_W'(pspd_reg));
        ysp     = signed'(DRV_W'(yspd_reg));
        m_ext   = LIM_W'(mpos_reg);
        dist_hi = (LIM_W+1)'(m_ext) - (LIM_W+1)'(hi_lim_reg);
        dist_lo = ZONE_W'(mpos_reg) - ZONE_W'(lower_reg);
        div_num = cmd.div_lo ? dist_lo[DIST_W-1:0] : dist_hi[DIST_W-1:0];
        ratio   = signed'(DRV_W'(quo));
    end

    tasel_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (zone_reg[DIST_W-1:0]),
        .quotient (quo),
        .stat     (stat)
    );

    always_ff @(posedge aclk) begin
        if (cmd.limit) begin
            hi_lim_reg <= LIM_W'(upper_reg) - LIM_W'(zone_reg);
            lo_lim_reg <= LIM_W'(lower_reg) + LIM_W'(zone_reg);
            y_reg      <= clamp_drv(slew(ydrive_reg, ydem_reg, ystep_reg), -ysp, ysp);
        end
        if (cmd.div_start && !cmd.div_lo) begin
            up_past_reg <= (mpos_reg > upper_reg);
            up_zone_reg <= (m_ext > hi_lim_reg);
            lo_past_reg <= (mpos_reg < lower_reg);
            lo_zone_reg <= (m_ext < lo_lim_reg);
        end
    end

    // in either zone branch the distance lies within the zone, so the
    // quotient never exceeds one
    always_ff @(posedge aclk) begin
        if (cmd.limit) begin
            p_reg <= clamp_drv(slew(pdrive_reg, pdem_reg, pstep_reg), -psp, psp);
        end else if (cmd.apply_hi) begin
            if (up_past_reg) begin
                p_reg <= clamp_drv(p_reg, '0, psp);
            end else if (up_zone_reg) begin
                p_reg <= clamp_drv(p_reg, ratio - DRV_ONE, psp);
            end
        end else if (cmd.apply_lo) begin
            if (lo_past_reg) begin
                p_reg <= clamp_drv(p_reg, -psp, '0);
            end else if (lo_zone_reg) begin
                p_reg <= clamp_drv(p_reg, -psp, ratio);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pdrive_reg <= '0;
            ydrive_reg <= '0;
        end else if (cmd.commit) begin
            pdrive_reg <= p_reg;
            ydrive_reg <= y_reg;
        end
    end

    assign pitch_drive = pdrive_reg;
    assign yaw_drive   = ydrive_reg;

endmodule

### sv/tasel_ctrl.sv
`timescale 1ns / 1ps
`include "two_axis_slew_and_end_limiter_core_assert.svh"

module tasel_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tasel_pkg::cmd_t   cmd,
    input  tasel_pkg::stat_t  stat
);
    import tasel_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_MUL_P;
            ST_MUL_P:    state_next = ST_MUL_Y;
            ST_MUL_Y:    state_next = ST_MUL_Z;
            ST_MUL_Z:    state_next = ST_LIMIT;
            ST_LIMIT:    state_next = ST_DIVH_GO;
            ST_DIVH_GO:  state_next = ST_DIVH_RUN;
            ST_DIVH_RUN: if (stat.div_last) state_next = ST_APPLY_HI;
            ST_APPLY_HI: state_next = ST_DIVL_GO;
            ST_DIVL_GO:  state_next = ST_DIVL_RUN;
            ST_DIVL_RUN: if (stat.div_last) state_next = ST_APPLY_LO;
            ST_APPLY_LO: state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:     cmd.load = s_valid;
            ST_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PITCH;
            end
            ST_MUL_Y: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_YAW;
            end
            ST_MUL_Z: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ZONE;
            end
            ST_LIMIT:    cmd.limit = 1'b1;
            ST_DIVH_GO:  cmd.div_start = 1'b1;
            ST_DIVH_RUN: ;
            ST_APPLY_HI: cmd.apply_hi = 1'b1;
            ST_DIVL_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_lo    = 1'b1;
            end
            ST_DIVL_RUN: cmd.div_lo = 1'b1;
            ST_APPLY_LO: cmd.apply_lo = 1'b1;
            ST_DONE:     cmd.commit = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `TASEL_ASSERT_IMP(a_commit_slot, aclk, aresetn, cmd.commit, !m_valid_reg || m_ready)
    `TASEL_ASSERT_NXT(a_commit_out, aclk, aresetn, cmd.commit, m_valid_reg && state_reg == ST_IDLE)
    `TASEL_ASSERT_IMP(a_run_busy, aclk, aresetn, state_reg == ST_DIVH_RUN || state_reg == ST_DIVL_RUN, stat.div_busy)
    `TASEL_ASSERT_IMP(a_idle_div, aclk, aresetn, state_reg == ST_IDLE, !stat.div_busy)

endmodule

### sv/two_axis_slew_and_end_limiter_core.sv
// Two-axis slew and end-of-travel limiter.
// Input channel (s_valid/s_ready): one word per control tick with pitch and
// yaw demands, speed and acceleration limits and the measured pitch position.
// Result channel (m_valid/m_ready): one word per input word with the new
// pitch and yaw drive values; these are also the stored drive state.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr
// (0 upper limit, 1 lower limit, 2 time step, 3 slow fraction; other
// addresses are ignored). Write only while no word is in flight.
// Each word passes in turn through the shared 17x17 multiplier (three passes),
// the limit step and two serial divides for the upper and lower slowdown
// ratios; a new word is taken only after the previous result is committed.
// s_ready is high only while the core is idle; a new word is taken while the
// previous result still waits on m_ready.
// If the receiver stalls, the finished word waits in the last state until the
// output register is free; the payload holds while m_valid is high.
// Reset (aresetn low, synchronous) clears both drives to zero, restores the
// configuration defaults and drops m_valid.
`timescale 1ns / 1ps

module two_axis_slew_and_end_limiter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tasel_pkg::DRV_W-1:0]  s_pitch_demand,
    input  logic signed [tasel_pkg::DRV_W-1:0]  s_yaw_demand,
    input  logic [tasel_pkg::SPD_W-1:0]         s_pitch_speed_limit,
    input  logic [tasel_pkg::SPD_W-1:0]         s_yaw_speed_limit,
    input  logic [tasel_pkg::ACC_W-1:0]         s_pitch_accel_limit,
    input  logic [tasel_pkg::ACC_W-1:0]         s_yaw_accel_limit,
    input  logic signed [tasel_pkg::POS_W-1:0]  s_measured_pitch_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tasel_pkg::DRV_W-1:0]  m_pitch_drive_out,
    output logic signed [tasel_pkg::DRV_W-1:0]  m_yaw_drive_out,
    input  logic                                cfg_wr_en,
    input  logic [tasel_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tasel_pkg::CFG_W-1:0]         cfg_wdata
);
    import tasel_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tasel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    tasel_dp u_dp (
        .aclk                       (aclk),
        .aresetn                    (aresetn),
        .cmd                        (cmd),
        .stat                       (stat),
        .cfg_wr_en                  (cfg_wr_en),
        .cfg_addr                   (cfg_addr),
        .cfg_wdata                  (cfg_wdata),
        .in_pitch_demand            (s_pitch_demand),
        .in_yaw_demand              (s_yaw_demand),
        .in_pitch_speed_limit       (s_pitch_speed_limit),
        .in_yaw_speed_limit         (s_yaw_speed_limit),
        .in_pitch_accel_limit       (s_pitch_accel_limit),
        .in_yaw_accel_limit         (s_yaw_accel_limit),
        .in_measured_pitch_position (s_measured_pitch_position),
        .pitch_drive                (m_pitch_drive_out),
        .yaw_drive                  (m_yaw_drive_out)
    );

endmodule
